@@ rtl/ocu_pkg.sv @@
// Orbit camera update: shared types, constants and helper functions.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ocu_pkg;

  localparam int ANGLE_BITS        = 16;
  localparam int SINCOS_ITERATIONS = 16;
  localparam int ITER_N   = (SINCOS_ITERATIONS < 24) ? SINCOS_ITERATIONS : 24;
  localparam int ITER_W   = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE      = 3'd0,
    REG_ROTATION_GAIN = 3'd1,
    REG_ZOOM_GAIN     = 3'd2,
    REG_HEIGHT_LO     = 3'd3,
    REG_HEIGHT_HI     = 3'd4,
    REG_MIN_DISTANCE  = 3'd5,
    REG_MAX_DISTANCE  = 3'd6,
    REG_TARGET_OFFSET = 3'd7
  } cfg_reg_t;

  localparam logic [6:0]  DEADZONE_RST      = 7'd35;
  localparam logic [15:0] ROTATION_GAIN_RST = 16'd256;
  localparam logic [15:0] ZOOM_GAIN_RST     = 16'd256;
  localparam logic [31:0] HEIGHT_LO_RST     = 32'd65536;
  localparam logic [31:0] HEIGHT_HI_RST     = 32'd524288;
  localparam logic [31:0] MIN_DISTANCE_RST  = 32'd131072;
  localparam logic [31:0] MAX_DISTANCE_RST  = 32'd655360;
  localparam logic [31:0] TARGET_OFFSET_RST = 32'd111411;

  typedef struct packed {
    logic        [15:0] speed_scale;
    logic signed [7:0]  x_axis;
    logic signed [7:0]  y_axis;
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;
    logic signed [31:0] player_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] look_y;
    logic        [15:0] orbit_angle;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  deadzone;
    logic [15:0] rotation_gain;
    logic [15:0] zoom_gain;
    logic [31:0] height_lo;
    logic [31:0] height_hi;
    logic [31:0] min_distance;
    logic [31:0] max_distance;
    logic [31:0] target_offset;
  } cfg_t;

  // classified frame tick as handed from front to back
  typedef struct packed {
    logic        [15:0] speed;
    logic        [7:0]  mag_x;
    logic               turn;
    logic               turn_left;
    logic        [7:0]  mag_y;
    logic               zoom;
    logic               zoom_near;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } work_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic idle;
    logic done;
  } back_stat_t;

  // atan(2^-i) as a fraction of one turn, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > ONE_Q30)       r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    else                   r = v;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ocu_front.sv @@
// Orbit camera front end: accepts frame ticks, applies the deadzone test
// and queues classified ticks in a two-entry FIFO. Uses ocu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocu_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  ocu_pkg::in_item_t      in_data,
  input  wire  [6:0]             deadzone,
  output logic                   work_valid,
  input  wire                    work_pop,
  output ocu_pkg::work_t         work_data,
  output ocu_pkg::front_stat_t   stat
);

  ocu_pkg::work_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic [7:0]     mag_x, mag_y;
  logic           push, pop;
  ocu_pkg::work_t cls;

  // |-128| is 128, which still fits in 8 unsigned bits
  assign mag_x = in_data.x_axis[7] ? 8'(-in_data.x_axis) : 8'(in_data.x_axis);
  assign mag_y = in_data.y_axis[7] ? 8'(-in_data.y_axis) : 8'(in_data.y_axis);

  always_comb begin
    cls.speed     = in_data.speed_scale;
    cls.mag_x     = mag_x;
    cls.turn      = mag_x > {1'b0, deadzone};
    cls.turn_left = in_data.x_axis[7];
    cls.mag_y     = mag_y;
    cls.zoom      = mag_y > {1'b0, deadzone};
    cls.zoom_near = !in_data.y_axis[7];
    cls.px        = in_data.player_x;
    cls.py        = in_data.player_y;
    cls.pz        = in_data.player_z;
  end

  assign in_stall   = count_r == 2'd2;
  assign push       = in_valid && !in_stall;
  assign work_valid = count_r != 2'd0;
  assign pop        = work_pop && work_valid;
  assign work_data  = q_r[rd_ptr_r];
  assign stat.full  = in_stall;
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

`default_nettype wire

@@ rtl/ocu_back.sv @@
// Orbit camera back end: sequencer with one shared multiplier and an
// iterative CORDIC; owns angle, height and distance. Uses ocu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocu_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ocu_pkg::cfg_t          cfg,
  input  wire                    work_valid,
  output logic                   work_pop,
  input  ocu_pkg::work_t         work_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output ocu_pkg::out_item_t     out_data,
  output ocu_pkg::back_stat_t    stat
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RX1  = 10'b0000000010,
    ST_RX2  = 10'b0000000100,
    ST_RY1  = 10'b0000001000,
    ST_RY2  = 10'b0000010000,
    ST_CORD = 10'b0000100000,
    ST_MC   = 10'b0001000000,
    ST_MS   = 10'b0010000000,
    ST_FIN  = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_t;

  localparam int AB = ocu_pkg::ANGLE_BITS;

  state_t state_r, state_nxt;
  ocu_pkg::work_t w_r;
  logic [AB-1:0]  angle_r;
  logic [31:0]    height_r, dist_r;
  logic signed [66:0] prod_r;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic [ocu_pkg::ITER_W-1:0] iter_r;
  logic signed [31:0] cos_r, sin_r;
  logic signed [31:0] camx_r;
  logic               out_valid_r;
  ocu_pkg::out_item_t res_r;
  ocu_pkg::out_item_t out_r;

  logic [AB-1:0]  step, angle_new;
  logic [31:0]    a32, a32f, zstep, d;
  logic           flip;
  logic signed [33:0] xs, ys;
  logic signed [35:0] prod_q;
  logic [31:0]    h_new, dist_new;
  logic           out_free;

  function automatic logic [31:0] move(input logic [31:0] v, input logic [31:0] lim,
                                       input logic [31:0] dd, input logic near);
    logic signed [33:0] r;
    r = {2'b0, v};
    if (near) begin
      if (v > lim) r = r - {2'b0, dd};
      if (r < $signed({2'b0, lim})) r = {2'b0, lim};
    end else begin
      if (v < lim) r = r + {2'b0, dd};
      if (r > $signed({2'b0, lim})) r = {2'b0, lim};
    end
    return r[31:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign work_pop  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stat.idle = state_r == ST_IDLE;
  assign stat.done = state_r == ST_OUT && out_free;

  always_comb begin
    unique case (state_r)
      ST_RX1:  begin mul_a = 34'(w_r.speed); mul_b = 33'(w_r.mag_x); end
      ST_RX2:  begin mul_a = 34'(prod_r[23:0]); mul_b = 33'(cfg.rotation_gain); end
      ST_RY1:  begin mul_a = 34'(w_r.speed); mul_b = 33'(w_r.mag_y); end
      ST_RY2:  begin mul_a = 34'(prod_r[23:0]); mul_b = 33'(cfg.zoom_gain); end
      ST_MC:   begin mul_a = 34'(dist_r); mul_b = 33'(cos_r); end
      ST_MS:   begin mul_a = 34'(dist_r); mul_b = 33'(sin_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // angle step and zoom step, taken from the registered products
  assign step      = prod_r[24 +: AB];
  assign angle_new = w_r.turn_left ? angle_r - step : angle_r + step;
  assign d         = prod_r[39:8];
  assign h_new     = move(height_r, w_r.zoom_near ? cfg.height_lo : cfg.height_hi,
                          d, w_r.zoom_near);
  assign dist_new  = move(dist_r, w_r.zoom_near ? cfg.min_distance : cfg.max_distance,
                          d, w_r.zoom_near);

  // reduce by a half turn into [-1/4, 1/4) turn
  assign a32  = {angle_r, {(32 - AB){1'b0}}};
  assign flip = a32[31] ^ a32[30];
  assign a32f = flip ? a32 + 32'h80000000 : a32;

  assign xs     = cx_r >>> iter_r;
  assign ys     = cy_r >>> iter_r;
  assign zstep  = ocu_pkg::atan_turn(iter_r);
  assign prod_q = 36'(prod_r >>> 30);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (work_valid) state_nxt = ST_RX1;
      ST_RX1:  state_nxt = ST_RX2;
      ST_RX2:  state_nxt = ST_RY1;
      ST_RY1:  state_nxt = ST_RY2;
      ST_RY2:  state_nxt = ST_CORD;
      ST_CORD: if (iter_r == ocu_pkg::ITER_W'(ocu_pkg::ITER_N)) state_nxt = ST_MC;
      ST_MC:   state_nxt = ST_MS;
      ST_MS:   state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      angle_r     <= ocu_pkg::ANGLE_RESET;
      height_r    <= ocu_pkg::HEIGHT_HI_RST;
      dist_r      <= ocu_pkg::MAX_DISTANCE_RST;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RY1 && w_r.turn) angle_r <= angle_new;
      if (state_r == ST_CORD && w_r.zoom && iter_r == '0) begin
        height_r <= h_new;
        dist_r   <= dist_new;
      end
      if (state_r == ST_RY2) iter_r <= '0;
      else if (state_r == ST_CORD) iter_r <= iter_r + 1'b1;
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 67'(mul_a * mul_b);
    if (state_r == ST_IDLE) w_r <= work_data;
    // the zoom product stays in prod_r through the first CORDIC step
    if (state_r == ST_RY2) begin
      cx_r   <= ocu_pkg::CORDIC_GAIN;
      cy_r   <= '0;
      flip_r <= flip;
    end else if (state_r == ST_CORD &&
                 iter_r != ocu_pkg::ITER_W'(ocu_pkg::ITER_N)) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - $signed({2'b0, zstep});
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + $signed({2'b0, zstep});
      end
    end
    if (state_r == ST_RY2) cz_r <= 34'($signed(a32f));
    if (state_r == ST_CORD && iter_r == ocu_pkg::ITER_W'(ocu_pkg::ITER_N)) begin
      cos_r <= ocu_pkg::clamp_q30(flip_r ? -cx_r : cx_r);
      sin_r <= ocu_pkg::clamp_q30(flip_r ? -cy_r : cy_r);
    end
    if (state_r == ST_MS) camx_r <= ocu_pkg::sat32(36'(w_r.px) + prod_q);
    // staged so a result still waiting on the receiver is never overwritten
    if (state_r == ST_FIN) begin
      res_r.cam_x       <= camx_r;
      res_r.cam_y       <= ocu_pkg::sat32(36'(w_r.py) + 36'(height_r));
      res_r.cam_z       <= ocu_pkg::sat32(36'(w_r.pz) + prod_q);
      res_r.look_y      <= ocu_pkg::sat32(36'(w_r.py) + 36'(cfg.target_offset));
      res_r.orbit_angle <= a32[31:16];
    end
    if (state_r == ST_OUT && out_free) out_r <= res_r;
  end

endmodule

`default_nettype wire

@@ rtl/orbit_camera_update.sv @@
// Orbit camera update top level: configuration registers, front end, back end.
// Depends on ocu_pkg, ocu_front and ocu_back.
//
// Usage: one input transfer per frame tick (speed scale, stick axes, player
// position) on in_valid/in_stall/in_data; one result transfer per tick on
// out_valid/out_stall/out_data. The user must write configuration through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block itself does
// not enforce this. The back end steps each tick through the shared multiplier
// sequence and the iterative CORDIC loop, and takes no new tick from the FIFO
// until the result of the last one has been handed on.
// The front FIFO holds two ticks; in_stall rises only when it is full.
// Reset (rst_n low, synchronous) restores register defaults, angle to a
// quarter turn, height and distance to their maximum defaults, and empties
// the FIFO. While out_stall is high the result holds and the back end
// waits with its next result; the front keeps taking ticks until full.
`timescale 1ns / 1ps
`default_nettype none

module orbit_camera_update (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  ocu_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output ocu_pkg::out_item_t       out_data,
  input  wire                      cfg_we,
  input  wire  [ocu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [31:0]              cfg_wdata
);

  ocu_pkg::cfg_t        cfg_r;
  ocu_pkg::work_t       work_data;
  logic                 work_valid, work_pop;
  ocu_pkg::front_stat_t front_stat;
  ocu_pkg::back_stat_t  back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone      <= ocu_pkg::DEADZONE_RST;
      cfg_r.rotation_gain <= ocu_pkg::ROTATION_GAIN_RST;
      cfg_r.zoom_gain     <= ocu_pkg::ZOOM_GAIN_RST;
      cfg_r.height_lo     <= ocu_pkg::HEIGHT_LO_RST;
      cfg_r.height_hi     <= ocu_pkg::HEIGHT_HI_RST;
      cfg_r.min_distance  <= ocu_pkg::MIN_DISTANCE_RST;
      cfg_r.max_distance  <= ocu_pkg::MAX_DISTANCE_RST;
      cfg_r.target_offset <= ocu_pkg::TARGET_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (ocu_pkg::cfg_reg_t'(cfg_index))
        ocu_pkg::REG_DEADZONE:      cfg_r.deadzone      <= cfg_wdata[6:0];
        ocu_pkg::REG_ROTATION_GAIN: cfg_r.rotation_gain <= cfg_wdata[15:0];
        ocu_pkg::REG_ZOOM_GAIN:     cfg_r.zoom_gain     <= cfg_wdata[15:0];
        ocu_pkg::REG_HEIGHT_LO:     cfg_r.height_lo     <= cfg_wdata;
        ocu_pkg::REG_HEIGHT_HI:     cfg_r.height_hi     <= cfg_wdata;
        ocu_pkg::REG_MIN_DISTANCE:  cfg_r.min_distance  <= cfg_wdata;
        ocu_pkg::REG_MAX_DISTANCE:  cfg_r.max_distance  <= cfg_wdata;
        ocu_pkg::REG_TARGET_OFFSET: cfg_r.target_offset <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ocu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .deadzone   (cfg_r.deadzone),
    .work_valid (work_valid),
    .work_pop   (work_pop),
    .work_data  (work_data),
    .stat       (front_stat)
  );

  ocu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .work_valid (work_valid),
    .work_pop   (work_pop),
    .work_data  (work_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .stat       (back_stat)
  );

`ifndef SYNTHESIS
  a_new_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_stat.done))
    else $error("result appeared without a finished item");

  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.count != 2'd3)
    else $error("front FIFO count out of range");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.full |-> in_stall && !(work_valid && back_stat.idle && front_stat.count == 2'd0))
    else $error("front accepts while full");
`endif

endmodule

`default_nettype wire
